@@ rtl/vff_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the vertical FIR filter.
package vff_pkg;

  localparam int PIX_W      = 16;
  localparam int COEF_W     = 16;
  localparam int NCOEF      = 5;
  localparam int LW_W       = 11;
  localparam int TAP_W      = 3;
  localparam int SH_W       = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BANK_IDX_W = 4;
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int SUM_W      = PROD_W + 3;
  localparam int OUT_CAP    = 32768;

  localparam logic [LW_W-1:0]  LW_RESET  = LW_W'(1024);
  localparam logic [TAP_W-1:0] TAP_RESET = TAP_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH   = 3'd0,
    REG_TAP_COUNT    = 3'd1,
    REG_SHIFT_AMOUNT = 3'd2,
    REG_COEF_0       = 3'd3,
    REG_COEF_1       = 3'd4,
    REG_COEF_2       = 3'd5,
    REG_COEF_3       = 3'd6,
    REG_COEF_4       = 3'd7
  } cfg_reg_e;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic [LW_W-1:0]         line_width;
    logic [TAP_W-1:0]        tap_count;
    logic [SH_W-1:0]         shift_amount;
    coef_t [NCOEF-1:0]       coef;
  } cfg_t;

  // one multiplier lane: which row feeds coefficient j
  typedef struct packed {
    logic                  en;
    logic                  cur;
    logic [BANK_IDX_W-1:0] bank;
  } lane_t;

  typedef struct packed {
    logic                produce;
    logic                row_end;
    lane_t [NCOEF-1:0]   lane;
  } item_ctrl_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic             row_end;
  } res_t;

endpackage

@@ rtl/vff_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read (read-first).
module vff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ rtl/vff_line_ctrl.sv @@
`timescale 1ns / 1ps
// Column, row and line-slot tracking; picks the line bank for each tap.
module vff_line_ctrl #(
  parameter int MAX_TAPS = 5,
  parameter int MAX_LINE = 1024,
  localparam int NLINES  = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1,
  localparam int SLOT_W  = (NLINES > 1) ? $clog2(NLINES) : 1,
  localparam int COL_W   = $clog2(MAX_LINE)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          frame_start_i,
  input  logic [vff_pkg::LW_W-1:0]      line_width_i,
  input  logic [vff_pkg::TAP_W-1:0]     tap_count_i,
  output logic [COL_W-1:0]              col_o,
  output logic [SLOT_W-1:0]             wr_bank_o,
  output vff_pkg::item_ctrl_t           item_ctrl_o
);

  import vff_pkg::*;

  localparam int CNT_W    = $clog2(MAX_LINE + 1);
  localparam int WCMP_W   = (CNT_W > LW_W) ? CNT_W : LW_W;
  localparam int RS_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int ROWS_MAX = MAX_TAPS - 1;

  logic [COL_W-1:0]  col_q, col_d, col_use;
  logic [RS_W-1:0]   rows_q, rows_d, rows_use;
  logic [SLOT_W-1:0] newest_q, newest_d, newest_use;
  logic [WCMP_W-1:0] lw_ext, width_eff;
  logic [TAP_W-1:0]  taps;
  logic              last;

  always_comb begin
    lw_ext = WCMP_W'(line_width_i);
    if (lw_ext == '0) begin
      width_eff = WCMP_W'(1);
    end else if (lw_ext > WCMP_W'(MAX_LINE)) begin
      width_eff = WCMP_W'(MAX_LINE);
    end else begin
      width_eff = lw_ext;
    end

    if (tap_count_i == '0) begin
      taps = TAP_W'(1);
    end else if (5'(tap_count_i) > 5'(MAX_TAPS)) begin
      taps = TAP_W'(MAX_TAPS);
    end else begin
      taps = tap_count_i;
    end

    col_use    = frame_start_i ? '0 : col_q;
    rows_use   = frame_start_i ? '0 : rows_q;
    newest_use = frame_start_i ? '0 : newest_q;
    last       = (WCMP_W'(col_use) + WCMP_W'(1)) >= width_eff;
  end

  // tap k rows back sits in bank newest-k modulo the line count;
  // the oldest row of a full window shares the bank being written
  always_comb begin
    logic [4:0] k;
    logic [4:0] nw;
    item_ctrl_o.produce = 5'(rows_use) >= (5'(taps) - 5'd1);
    item_ctrl_o.row_end = last;
    nw = 5'(newest_use);
    for (int j = 0; j < NCOEF; j++) begin
      k = 5'(taps) - 5'd1 - 5'(j);
      item_ctrl_o.lane[j].en  = 5'(j) < 5'(taps);
      item_ctrl_o.lane[j].cur = (k == 5'd0);
      if (k == 5'(NLINES)) begin
        item_ctrl_o.lane[j].bank = BANK_IDX_W'(nw);
      end else if (nw >= k) begin
        item_ctrl_o.lane[j].bank = BANK_IDX_W'(nw - k);
      end else begin
        item_ctrl_o.lane[j].bank = BANK_IDX_W'(nw + 5'(NLINES) - k);
      end
    end
  end

  always_comb begin
    col_d    = col_q;
    rows_d   = rows_q;
    newest_d = newest_q;
    if (accept_i) begin
      if (last) begin
        col_d    = '0;
        newest_d = (newest_use == SLOT_W'(NLINES - 1)) ? '0 : newest_use + SLOT_W'(1);
        rows_d   = (rows_use < RS_W'(ROWS_MAX)) ? rows_use + RS_W'(1) : rows_use;
      end else begin
        col_d    = col_use + COL_W'(1);
        newest_d = newest_use;
        rows_d   = rows_use;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      rows_q   <= '0;
      newest_q <= '0;
    end else begin
      col_q    <= col_d;
      rows_q   <= rows_d;
      newest_q <= newest_d;
    end
  end

  assign col_o     = col_use;
  assign wr_bank_o = newest_use;

endmodule

@@ rtl/vff_mac.sv @@
`timescale 1ns / 1ps
// Tap multiply, sum, shift and clamp pipeline.
module vff_mac #(
  parameter int NLINES = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      accept_i,
  input  logic [vff_pkg::PIX_W-1:0] pixel_i,
  input  vff_pkg::item_ctrl_t       item_ctrl_i,
  input  logic [vff_pkg::PIX_W-1:0] rdata_i [NLINES],
  input  vff_pkg::cfg_t             cfg_i,
  output logic                      res_valid_o,
  output vff_pkg::res_t             res_o
);

  import vff_pkg::*;

  localparam int BANK_W = (NLINES > 1) ? $clog2(NLINES) : 1;

  // stage 1: item registers, line data comes straight from the RAMs
  logic                   s1_valid_q;
  logic                   s1_row_end_q;
  logic [PIX_W-1:0]       s1_pix_q;
  lane_t [NCOEF-1:0]      s1_lane_q;
  // stage 2: products
  logic                   s2_valid_q;
  logic                   s2_row_end_q;
  logic signed [PROD_W-1:0] s2_prod_q [NCOEF];
  logic signed [PROD_W-1:0] prod_d [NCOEF];
  // stage 3: sum
  logic                   s3_valid_q;
  logic                   s3_row_end_q;
  logic signed [SUM_W-1:0] s3_sum_q, sum_d;
  logic [SUM_W-1:0]       shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= accept_i && item_ctrl_i.produce;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_comb begin
    logic [PIX_W-1:0] val;
    for (int j = 0; j < NCOEF; j++) begin
      val = s1_lane_q[j].cur ? s1_pix_q : rdata_i[s1_lane_q[j].bank[BANK_W-1:0]];
      if (s1_lane_q[j].en) begin
        prod_d[j] = $signed({1'b0, val}) * $signed(cfg_i.coef[j]);
      end else begin
        prod_d[j] = '0;
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int j = 0; j < NCOEF; j++) begin
      sum_d = sum_d + SUM_W'(s2_prod_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_pix_q     <= pixel_i;
      s1_lane_q    <= item_ctrl_i.lane;
      s1_row_end_q <= item_ctrl_i.row_end;
      s2_prod_q    <= prod_d;
      s2_row_end_q <= s1_row_end_q;
      s3_sum_q     <= sum_d;
      s3_row_end_q <= s2_row_end_q;
    end
  end

  // negative sums clamp to zero; non-negative sums are shifted and then capped at OUT_CAP
  always_comb begin
    shifted = $unsigned(s3_sum_q) >> cfg_i.shift_amount;
    if (s3_sum_q[SUM_W-1]) begin
      res_o.filtered = '0;
    end else if (shifted > SUM_W'(OUT_CAP)) begin
      res_o.filtered = PIX_W'(OUT_CAP);
    end else begin
      res_o.filtered = shifted[PIX_W-1:0];
    end
    res_o.row_end = s3_row_end_q;
  end

  assign res_valid_o = s3_valid_q;

endmodule

@@ rtl/vff_skid.sv @@
`timescale 1ns / 1ps
// Output register with skid stage; the ready to the pipe is taken from the skid register.
module vff_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vff_pkg::res_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vff_pkg::res_t  out_data_o
);

  import vff_pkg::*;

  logic out_valid_q, skid_valid_q;
  res_t out_data_q, skid_data_q;
  logic out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_valid_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : in_data_i;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/vertical_fir_filter_u16_top.sv @@
`timescale 1ns / 1ps
// Vertical FIR filter over 16-bit pixels with banked line stores.
// Path: an accepted item passes the stage 1, product and sum registers, then the output register, to the master side.
// Throughput: one item per cycle while s_axis_tready is high; each tap reads its own line RAM bank in parallel.
// Backpressure: a skid stage holds one extra result; s_axis_tready drops only when it is full.
// Reset: asynchronous, active low; counters, valids and configuration registers return to defaults,
// line RAM contents are left as they are and need no clearing pass.
module vertical_fir_filter_u16_top #(
  parameter int MAX_TAPS = 5,
  parameter int MAX_LINE = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [vff_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [vff_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // pixel input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // [15:0] pixel
  input  logic                              s_axis_tuser,  // [0] frame_start
  // filtered output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // [15:0] filtered
  output logic                              m_axis_tlast   // row_end
);

  import vff_pkg::*;

  localparam int NLINES = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
  localparam int SLOT_W = (NLINES > 1) ? $clog2(NLINES) : 1;
  localparam int COL_W  = $clog2(MAX_LINE);

  cfg_t              cfg_q;
  logic              accept, pipe_adv;
  logic [COL_W-1:0]  col;
  logic [SLOT_W-1:0] wr_bank;
  item_ctrl_t        item_ctrl;
  logic [PIX_W-1:0]  rdata [NLINES];
  logic              res_valid;
  res_t              res, out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width   <= LW_RESET;
      cfg_q.tap_count    <= TAP_RESET;
      cfg_q.shift_amount <= '0;
      cfg_q.coef         <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LINE_WIDTH:   cfg_q.line_width   <= cfg_data_i[LW_W-1:0];
        REG_TAP_COUNT:    cfg_q.tap_count    <= cfg_data_i[TAP_W-1:0];
        REG_SHIFT_AMOUNT: cfg_q.shift_amount <= cfg_data_i[SH_W-1:0];
        REG_COEF_0:       cfg_q.coef[0]      <= cfg_data_i;
        REG_COEF_1:       cfg_q.coef[1]      <= cfg_data_i;
        REG_COEF_2:       cfg_q.coef[2]      <= cfg_data_i;
        REG_COEF_3:       cfg_q.coef[3]      <= cfg_data_i;
        REG_COEF_4:       cfg_q.coef[4]      <= cfg_data_i;
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  assign s_axis_tready = pipe_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  vff_line_ctrl #(
    .MAX_TAPS (MAX_TAPS),
    .MAX_LINE (MAX_LINE)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .frame_start_i (s_axis_tuser),
    .line_width_i  (cfg_q.line_width),
    .tap_count_i   (cfg_q.tap_count),
    .col_o         (col),
    .wr_bank_o     (wr_bank),
    .item_ctrl_o   (item_ctrl)
  );

  // one RAM per stored row; all banks read the same column each item
  for (genvar b = 0; b < NLINES; b++) begin : g_line
    vff_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_LINE)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (accept && (wr_bank == SLOT_W'(b))),
      .waddr_i (col),
      .wdata_i (s_axis_tdata),
      .re_i    (accept),
      .raddr_i (col),
      .rdata_o (rdata[b])
    );
  end

  vff_mac #(
    .NLINES (NLINES)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (pipe_adv),
    .accept_i    (accept),
    .pixel_i     (s_axis_tdata),
    .item_ctrl_i (item_ctrl),
    .rdata_i     (rdata),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  vff_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (pipe_adv),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = out_res.filtered;
  assign m_axis_tlast = out_res.row_end;

  a_out_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata <= 16'(OUT_CAP)))
    else $error("filtered value above clamp bound");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output register");

  a_bank_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (32'(wr_bank) < NLINES))
    else $error("line slot out of range");

  a_frame_start_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser) |-> (col == '0))
    else $error("frame start did not restart column");

endmodule
